// ===== design/gmf_pkg.sv =====
// Shared types, register codes and helper functions for the grayscale morphology filter.
// No dependencies; imported by every module of the block.
package gmf_pkg;

  localparam int PIX_W      = 8;
  localparam int RES_W      = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 49;

  localparam int COLQ_DEPTH = 4;
  localparam int COLQ_PTR_W = 2;
  localparam int COLQ_LVL_W = 3;
  localparam int OUTQ_DEPTH = 8;
  localparam int OUTQ_PTR_W = 3;
  localparam int OUTQ_CNT_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT,
    REG_MASK_SIZE,
    REG_MASK_BITS,
    REG_FILTER_MODE
  } cfg_reg_t;

  localparam logic CMD_PIXEL  = 1'b0;
  localparam logic MODE_ERODE = 1'b1;

  localparam logic [RES_W-1:0] ERODE_EMPTY  = 9'd256;
  localparam logic [RES_W-1:0] DILATE_EMPTY = 9'd0;

  localparam logic [10:0] RST_FRAME_WIDTH  = 11'd1024;
  localparam logic [10:0] RST_FRAME_HEIGHT = 11'd1024;
  localparam logic [2:0]  RST_MASK_SIZE    = 3'd3;
  localparam logic [48:0] RST_MASK_BITS    = 49'd511;
  localparam logic        RST_FILTER_MODE  = 1'b0;

  typedef struct packed {
    logic [10:0] frame_width;
    logic [10:0] frame_height;
    logic [2:0]  mask_size;
    logic [48:0] mask_bits;
    logic        filter_mode;
  } cfg_t;

  typedef struct packed {
    logic emit;
    logic last;
    logic row_start;
    logic col_valid;
  } col_flags_t;

  function automatic logic [2:0] eff_size(input logic [2:0] ms, input logic [2:0] lim);
    logic [2:0] s;
    s = ms | 3'd1;
    if (s > lim) s = lim;
    return s;
  endfunction

  function automatic logic [RES_W-1:0] pick(input logic mode, input logic [RES_W-1:0] a,
                                            input logic [RES_W-1:0] b);
    if (mode == MODE_ERODE) return (b < a) ? b : a;
    return (b > a) ? b : a;
  endfunction

endpackage

// ===== design/gmf_front.sv =====
// Front end: frame counters, result scheduling, line store banks and column reads.
// Depends on gmf_pkg; feeds column records into gmf_colq.
module gmf_front import gmf_pkg::*; #(
  parameter int SMAX       = 7,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cfg_t                        cfg,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic                        in_cmd,
  input  logic [PIX_W-1:0]            in_pixel_value,
  input  logic [COLQ_LVL_W-1:0]       q_level,
  output logic                        q_push,
  output logic [SMAX-1:0][PIX_W-1:0]  q_pix,
  output logic [SMAX-1:0]             q_rv,
  output col_flags_t                  q_flags
);

  localparam int HMAX = SMAX / 2;
  localparam int NB   = 2 ** $clog2(SMAX + 1);
  localparam int BW   = $clog2(NB);
  localparam int CW   = $clog2(MAX_WIDTH + 1);
  localparam int RW   = $clog2(MAX_HEIGHT + 1);
  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int LW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

  logic [CW-1:0] w_e;
  logic [RW-1:0] h_e;
  logic [2:0]    s_e;
  logic [1:0]    half;
  logic [LW-1:0] thr;

  logic [RW-1:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [CW-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [LW-1:0] lag_r, lag_nxt;

  logic          job_v_r, job_v_nxt;
  logic [RW-1:0] job_row_r;
  logic [CW-1:0] job_col_r;
  logic          job_last_r;
  logic [1:0]    prime_r, prime_nxt;

  logic             rd_v_r;
  logic [BW-1:0]    rd_rowlo_r;
  logic [SMAX-1:0]  rd_rv_r;
  col_flags_t       rd_flags_r;
  logic [PIX_W-1:0] rdat_r [NB];
  logic [PIX_W-1:0] mem [NB][MAX_WIDTH];

  logic          accept, do_write, ready, last, in_done, done2, clr;
  logic          wrap_i, wrap_o, wrap_w;
  logic [RW:0]   ir0, or0;
  logic [RW-1:0] ir1, or1;
  logic [CW-1:0] ic1, oc1;
  logic [CW:0]   ic_inc, oc_inc;
  logic [LW-1:0] lag1;

  logic          room, issue, final_col;
  logic [CW:0]   rx;
  logic [SMAX-1:0] iss_rv;
  col_flags_t    iss_flags;

  always_comb begin
    if (cfg.frame_width == '0) w_e = CW'(1);
    else if (32'(cfg.frame_width) > MAX_WIDTH) w_e = CW'(MAX_WIDTH);
    else w_e = CW'(cfg.frame_width);
    if (cfg.frame_height == '0) h_e = RW'(1);
    else if (32'(cfg.frame_height) > MAX_HEIGHT) h_e = RW'(MAX_HEIGHT);
    else h_e = RW'(cfg.frame_height);
    s_e  = eff_size(cfg.mask_size, 3'(SMAX));
    half = s_e[2:1];
    thr  = LW'(half) * (LW'(w_e) + LW'(1));
  end

  // issue side: one column read per cycle while the column queue has room, priming columns at the start of a row
  always_comb begin
    room      = ({1'b0, q_level} + (COLQ_LVL_W + 1)'(rd_v_r)) < (COLQ_LVL_W + 1)'(COLQ_DEPTH);
    issue     = job_v_r && room;
    final_col = (job_col_r != '0) || (prime_r == half);
    rx        = (job_col_r == '0) ? (CW + 1)'(prime_r)
                                  : {1'b0, job_col_r} + (CW + 1)'(half);
    for (int i = 0; i < SMAX; i++) begin
      iss_rv[i] = (int'(job_row_r) + i >= HMAX) && (int'(job_row_r) + i - HMAX < int'(h_e));
    end
    iss_flags.emit      = final_col;
    iss_flags.last      = job_last_r;
    iss_flags.row_start = (job_col_r == '0) && (prime_r == 2'd0);
    iss_flags.col_valid = rx < {1'b0, w_e};
    in_full = job_v_r && !(issue && final_col);
    accept  = in_push && !in_full;
  end

  // item side: normalize counters, store pixel, decide whether a result is due
  always_comb begin
    wrap_i = in_col_r >= w_e;
    wrap_o = out_col_r >= w_e;
    ir0    = {1'b0, in_row_r} + (RW + 1)'(wrap_i);
    or0    = {1'b0, out_row_r} + (RW + 1)'(wrap_o);
    clr    = or0 >= {1'b0, h_e};
    ic1    = (clr || wrap_i) ? '0 : in_col_r;
    oc1    = (clr || wrap_o) ? '0 : out_col_r;
    ir1    = clr ? '0 : ((ir0 > {1'b0, h_e}) ? h_e : ir0[RW-1:0]);
    or1    = clr ? '0 : or0[RW-1:0];
    lag1   = clr ? '0 : lag_r;
    in_done  = ir1 >= h_e;
    do_write = accept && !in_done && (in_cmd == CMD_PIXEL);
    ic_inc   = {1'b0, ic1} + (CW + 1)'(1);
    wrap_w   = ic_inc >= {1'b0, w_e};
    done2    = in_done || (do_write && wrap_w && (ir1 == h_e - RW'(1)));
    ready    = accept && (done2 || (do_write && (lag1 >= thr)));
    last     = (or1 == h_e - RW'(1)) && (oc1 == w_e - CW'(1));
    oc_inc   = {1'b0, oc1} + (CW + 1)'(1);

    in_row_nxt  = in_row_r;
    in_col_nxt  = in_col_r;
    out_row_nxt = out_row_r;
    out_col_nxt = out_col_r;
    lag_nxt     = lag_r;
    if (accept) begin
      in_row_nxt  = ir1;
      in_col_nxt  = ic1;
      out_row_nxt = or1;
      out_col_nxt = oc1;
      lag_nxt     = lag1;
      if (do_write) begin
        in_col_nxt = wrap_w ? '0 : ic_inc[CW-1:0];
        in_row_nxt = ir1 + RW'(wrap_w);
        lag_nxt    = lag1 + LW'(1);
      end
      if (ready) begin
        if (last) begin
          in_row_nxt  = '0;
          in_col_nxt  = '0;
          out_row_nxt = '0;
          out_col_nxt = '0;
          lag_nxt     = '0;
        end else begin
          lag_nxt = lag_nxt - LW'(1);
          if (oc_inc >= {1'b0, w_e}) begin
            out_col_nxt = '0;
            out_row_nxt = or1 + RW'(1);
          end else begin
            out_col_nxt = oc_inc[CW-1:0];
          end
        end
      end
    end

    job_v_nxt = job_v_r;
    prime_nxt = prime_r;
    if (issue) begin
      if (final_col) job_v_nxt = 1'b0;
      else prime_nxt = prime_r + 2'd1;
    end
    if (ready) begin
      job_v_nxt = 1'b1;
      prime_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_row_r  <= '0;
      in_col_r  <= '0;
      out_row_r <= '0;
      out_col_r <= '0;
      lag_r     <= '0;
      job_v_r   <= 1'b0;
      prime_r   <= 2'd0;
      rd_v_r    <= 1'b0;
    end else begin
      in_row_r  <= in_row_nxt;
      in_col_r  <= in_col_nxt;
      out_row_r <= out_row_nxt;
      out_col_r <= out_col_nxt;
      lag_r     <= lag_nxt;
      job_v_r   <= job_v_nxt;
      prime_r   <= prime_nxt;
      rd_v_r    <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (ready) begin
      job_row_r  <= or1;
      job_col_r  <= oc1;
      job_last_r <= last;
    end
    if (issue) begin
      rd_rowlo_r <= job_row_r[BW-1:0];
      rd_rv_r    <= iss_rv;
      rd_flags_r <= iss_flags;
    end
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < NB; b++) begin
      if (do_write && (ir1[BW-1:0] == BW'(b))) mem[b][ic1[AW-1:0]] <= in_pixel_value;
      if (issue) rdat_r[b] <= mem[b][rx[AW-1:0]];
    end
  end

  always_comb begin
    q_push  = rd_v_r;
    q_rv    = rd_rv_r;
    q_flags = rd_flags_r;
    for (int i = 0; i < SMAX; i++) begin
      q_pix[i] = rdat_r[BW'(int'(rd_rowlo_r) + NB - HMAX + i)];
    end
  end

`ifndef NO_ASSERTIONS
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    rd_v_r |-> (q_level < COLQ_LVL_W'(COLQ_DEPTH)))
    else $error("column record pushed into a full queue");
  a_prime_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (job_v_r && (job_col_r == '0)) |-> (prime_r <= half))
    else $error("priming ran past the window half");
`endif

endmodule

// ===== design/gmf_colq.sv =====
// Short queue of column records between the front end and the window engine.
// Depends on gmf_pkg.
module gmf_colq import gmf_pkg::*; #(
  parameter int SMAX = 7
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  logic [SMAX-1:0][PIX_W-1:0]  push_pix,
  input  logic [SMAX-1:0]             push_rv,
  input  col_flags_t                  push_flags,
  input  logic                        pop,
  output logic                        empty,
  output logic [COLQ_LVL_W-1:0]       level,
  output logic [SMAX-1:0][PIX_W-1:0]  head_pix,
  output logic [SMAX-1:0]             head_rv,
  output col_flags_t                  head_flags
);

  logic [SMAX-1:0][PIX_W-1:0] pix_q [COLQ_DEPTH];
  logic [SMAX-1:0]            rv_q [COLQ_DEPTH];
  col_flags_t                 flags_q [COLQ_DEPTH];
  logic [COLQ_PTR_W-1:0]      wp_r, wp_nxt, rp_r, rp_nxt;
  logic [COLQ_LVL_W-1:0]      cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = push ? wp_r + COLQ_PTR_W'(1) : wp_r;
    rp_nxt  = pop ? rp_r + COLQ_PTR_W'(1) : rp_r;
    cnt_nxt = cnt_r + COLQ_LVL_W'(push) - COLQ_LVL_W'(pop);
    empty      = cnt_r == '0;
    level      = cnt_r;
    head_pix   = pix_q[rp_r];
    head_rv    = rv_q[rp_r];
    head_flags = flags_q[rp_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      pix_q[wp_r]   <= push_pix;
      rv_q[wp_r]    <= push_rv;
      flags_q[wp_r] <= push_flags;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |-> (cnt_r < COLQ_LVL_W'(COLQ_DEPTH)))
    else $error("column queue overflow");
`endif

endmodule

// ===== design/gmf_back.sv =====
// Window engine: sliding column window, two-level max/min reduction and result queue.
// Depends on gmf_pkg; drains records from gmf_colq.
module gmf_back import gmf_pkg::*; #(
  parameter int SMAX = 7
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cfg_t                        cfg,
  input  logic                        q_empty,
  input  logic [SMAX-1:0][PIX_W-1:0]  q_pix,
  input  logic [SMAX-1:0]             q_rv,
  input  col_flags_t                  q_flags,
  output logic                        q_pop,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [RES_W-1:0]            out_result_value,
  output logic                        out_result_last
);

  localparam int HMAX = SMAX / 2;

  logic [SMAX-1:0][PIX_W-1:0] win_pix_r [SMAX];
  logic [SMAX-1:0]            win_cv_r;
  logic [SMAX-1:0]            win_rv_r;
  logic                       emit_r, wlast_r;

  logic [RES_W-1:0]           part_r [SMAX];
  logic [RES_W-1:0]           part_c [SMAX];
  logic                       s1_v_r, s1_last_r;

  logic [RES_W-1:0]           fifo_val [OUTQ_DEPTH];
  logic                       fifo_last [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0]      wp_r, wp_nxt, rp_r, rp_nxt;
  logic [OUTQ_CNT_W-1:0]      cnt_r, cnt_nxt;

  logic [2:0]                 s_e;
  logic [1:0]                 half;
  logic [RES_W-1:0]           ident, res_c;
  logic                       msel [SMAX][SMAX];
  logic                       out_take;

  always_comb begin
    int l;
    int k;
    int bitn;
    s_e   = eff_size(cfg.mask_size, 3'(SMAX));
    half  = s_e[2:1];
    ident = (cfg.filter_mode == MODE_ERODE) ? ERODE_EMPTY : DILATE_EMPTY;
    for (int j = 0; j < SMAX; j++) begin
      for (int i = 0; i < SMAX; i++) begin
        l    = 2 * int'(half) - j;
        k    = i - HMAX + int'(half);
        bitn = k * int'(s_e) + l;
        msel[j][i] = (l >= 0) && (k >= 0) && (k < int'(s_e)) &&
                     cfg.mask_bits[6'(bitn)];
      end
    end
  end

  always_comb begin
    logic [RES_W-1:0] acc;
    for (int j = 0; j < SMAX; j++) begin
      acc = ident;
      for (int i = 0; i < SMAX; i++) begin
        if (msel[j][i] && win_cv_r[j] && win_rv_r[i]) begin
          acc = pick(cfg.filter_mode, acc, {1'b0, win_pix_r[j][i]});
        end
      end
      part_c[j] = acc;
    end
    res_c = ident;
    for (int j = 0; j < SMAX; j++) res_c = pick(cfg.filter_mode, res_c, part_r[j]);
  end

  always_comb begin
    q_pop = !q_empty &&
            ((5'(cnt_r) + 5'(emit_r) + 5'(s1_v_r)) < 5'(OUTQ_DEPTH));
    out_empty        = cnt_r == '0;
    out_take         = out_pop && !out_empty;
    out_result_value = fifo_val[rp_r];
    out_result_last  = fifo_last[rp_r];
    wp_nxt  = s1_v_r ? wp_r + OUTQ_PTR_W'(1) : wp_r;
    rp_nxt  = out_take ? rp_r + OUTQ_PTR_W'(1) : rp_r;
    cnt_nxt = cnt_r + OUTQ_CNT_W'(s1_v_r) - OUTQ_CNT_W'(out_take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_r   <= 1'b0;
      s1_v_r   <= 1'b0;
      win_cv_r <= '0;
      wp_r     <= '0;
      rp_r     <= '0;
      cnt_r    <= '0;
    end else begin
      emit_r <= q_pop && q_flags.emit;
      s1_v_r <= emit_r;
      if (q_pop) begin
        for (int j = 1; j < SMAX; j++) begin
          win_cv_r[j] <= q_flags.row_start ? 1'b0 : win_cv_r[j-1];
        end
        win_cv_r[0] <= q_flags.col_valid;
      end
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int j = 1; j < SMAX; j++) win_pix_r[j] <= win_pix_r[j-1];
      win_pix_r[0] <= q_pix;
      win_rv_r     <= q_rv;
      wlast_r      <= q_flags.last;
    end
    if (emit_r) begin
      for (int j = 0; j < SMAX; j++) part_r[j] <= part_c[j];
      s1_last_r <= wlast_r;
    end
    if (s1_v_r) begin
      fifo_val[wp_r]  <= res_c;
      fifo_last[wp_r] <= s1_last_r;
    end
  end

`ifndef NO_ASSERTIONS
  a_outq_room: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> (cnt_r < OUTQ_CNT_W'(OUTQ_DEPTH)))
    else $error("result written into a full result queue");
`endif

endmodule

// ===== design/grayscale_morphology_filter.sv =====
// Grayscale dilation/erosion over a raster pixel stream with a square mask of up to 7x7.
// Throughput: one item per cycle while in_full is low; a new output row adds column priming
// reads from the line store banks. A result passes the job register, bank read, column queue,
// window and partial reduce stages after the item that completes its window.
// Reset (rst_n low, synchronous) restores register defaults and empties all queues; the line
// store is not cleared.
module grayscale_morphology_filter import gmf_pkg::*; #(
  parameter int MAX_MASK   = 7,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic                  in_cmd,
  input  logic [PIX_W-1:0]      in_pixel_value,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [RES_W-1:0]      out_result_value,
  output logic                  out_result_last,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SMAX = (MAX_MASK - 1) | 1;

  cfg_t cfg_r, cfg_nxt;

  logic                       q_push, q_pop, q_empty;
  logic [COLQ_LVL_W-1:0]      q_level;
  logic [SMAX-1:0][PIX_W-1:0] qi_pix, qo_pix;
  logic [SMAX-1:0]            qi_rv, qo_rv;
  col_flags_t                 qi_flags, qo_flags;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  cfg_nxt.frame_width  = cfg_data[10:0];
        REG_FRAME_HEIGHT: cfg_nxt.frame_height = cfg_data[10:0];
        REG_MASK_SIZE:    cfg_nxt.mask_size    = cfg_data[2:0];
        REG_MASK_BITS:    cfg_nxt.mask_bits    = cfg_data[48:0];
        REG_FILTER_MODE:  cfg_nxt.filter_mode  = cfg_data[0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width  <= RST_FRAME_WIDTH;
      cfg_r.frame_height <= RST_FRAME_HEIGHT;
      cfg_r.mask_size    <= RST_MASK_SIZE;
      cfg_r.mask_bits    <= RST_MASK_BITS;
      cfg_r.filter_mode  <= RST_FILTER_MODE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  gmf_front #(
    .SMAX       (SMAX),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_cmd         (in_cmd),
    .in_pixel_value (in_pixel_value),
    .q_level        (q_level),
    .q_push         (q_push),
    .q_pix          (qi_pix),
    .q_rv           (qi_rv),
    .q_flags        (qi_flags)
  );

  gmf_colq #(
    .SMAX (SMAX)
  ) u_colq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_pix   (qi_pix),
    .push_rv    (qi_rv),
    .push_flags (qi_flags),
    .pop        (q_pop),
    .empty      (q_empty),
    .level      (q_level),
    .head_pix   (qo_pix),
    .head_rv    (qo_rv),
    .head_flags (qo_flags)
  );

  gmf_back #(
    .SMAX (SMAX)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_empty          (q_empty),
    .q_pix            (qo_pix),
    .q_rv             (qo_rv),
    .q_flags          (qo_flags),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_result_value (out_result_value),
    .out_result_last  (out_result_last)
  );

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for grayscale_morphology_filter: directed table, then random frames.
// Predicts each window max/min in-line and checks every result transfer.
// Depends on gmf_pkg and the filter RTL in design/.
`timescale 1ns / 1ps

module tb_top;
  import gmf_pkg::*;

  localparam logic CMD_DRAIN   = 1'b1;
  localparam logic MODE_DILATE = 1'b0;
  localparam int   STORE_ROWS  = 8;
  localparam int   LINE_LEN    = 1024;
  localparam int   SETTLE_CYC  = 12;
  localparam int   STALL_LIMIT = 5000;
  localparam int   RANDOM_ITEMS = 600;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    cfg_reg_t    reg_idx;
    logic [48:0] data;
    logic        cmd;
    logic [7:0]  pix;
    bit          fixed;
    logic [8:0]  fix_val;
    logic        fix_last;
  } stim_row_t;

  typedef struct {
    logic [8:0] val;
    logic       last;
  } window_res_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_push, in_full, in_cmd;
  logic [PIX_W-1:0] in_pixel_value;
  logic out_empty, out_pop;
  logic [RES_W-1:0] out_result_value;
  logic out_result_last;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  grayscale_morphology_filter DUT (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_cmd(in_cmd), .in_pixel_value(in_pixel_value),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_result_value(out_result_value), .out_result_last(out_result_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [7:0]  line_mem [STORE_ROWS*LINE_LEN];
  logic [10:0] cf_width, cf_height;
  logic [2:0]  cf_size;
  logic [48:0] cf_bits;
  logic        cf_mode;
  int px_row, px_col, res_row, res_col;

  window_res_t pending_results[$];
  window_res_t head;
  stim_row_t   dir_rows[$];
  int  errors, items_sent, results_seen, frames_closed, settings_used;
  int  idle_cycles;
  bit  steady, frame_closed;

  task automatic report(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  task automatic window_step(input logic cmd, input logic [7:0] pix, output bit got,
                             output logic [8:0] val, output logic last);
    int w, hh, s, half, latest, k, l, y, x, acc, v;
    bit done;
    w  = (cf_width == 0) ? 1 : ((cf_width > LINE_LEN) ? LINE_LEN : cf_width);
    hh = (cf_height == 0) ? 1 : ((cf_height > 1024) ? 1024 : cf_height);
    s  = cf_size | 3'd1;
    half = s / 2;
    got = 0; val = '0; last = 0; latest = 0;
    if (px_col >= w) begin px_col = 0; px_row++; end
    if (res_col >= w) begin res_col = 0; res_row++; end
    if (res_row >= hh) begin px_row = 0; px_col = 0; res_row = 0; res_col = 0; end
    if (px_row > hh) px_row = hh;
    done = px_row >= hh;
    if (!done) begin
      if (cmd != CMD_PIXEL) return;
      line_mem[(px_row % STORE_ROWS) * LINE_LEN + px_col] = pix;
      latest = px_row * w + px_col;
      px_col++;
      if (px_col >= w) begin px_col = 0; px_row++; end
      done = px_row >= hh;
    end
    if (!(done || latest >= res_row * w + res_col + half * w + half)) return;
    last = (res_row == hh - 1) && (res_col == w - 1);
    acc = (cf_mode == MODE_ERODE) ? 256 : 0;
    for (k = 0; k < s; k++)
      for (l = 0; l < s; l++) begin
        y = res_row + k - half;
        x = res_col + l - half;
        if (y < 0 || y >= hh || x < 0 || x >= w) continue;
        if (!cf_bits[k * s + l]) continue;
        v = line_mem[(y % STORE_ROWS) * LINE_LEN + x];
        if (cf_mode == MODE_ERODE) begin
          if (v < acc) acc = v;
        end else if (v > acc) acc = v;
      end
    val = acc[8:0];
    got = 1;
    if (last) begin
      px_row = 0; px_col = 0; res_row = 0; res_col = 0;
    end else begin
      res_col++;
      if (res_col >= w) begin res_col = 0; res_row++; end
    end
  endtask

  task automatic send_item(input logic cmd, input logic [7:0] pix, input bit fixed,
                           input logic [8:0] fix_val, input logic fix_last);
    bit got;
    logic [8:0] val;
    logic last;
    if (!steady)
      while ($urandom_range(99) < 28) begin
        in_push <= 1'b0;
        @(posedge clk);
      end
    in_push <= 1'b1;
    in_cmd <= cmd;
    in_pixel_value <= pix;
    do @(posedge clk); while (in_full);
    items_sent++;
    steady = (items_sent >= 250) && (items_sent < 420);
    window_step(cmd, pix, got, val, last);
    if (got && last) frame_closed = 1;
    if (fixed) pending_results.push_back('{fix_val, fix_last});
    else if (got) pending_results.push_back('{val, last});
  endtask

  task automatic settle();
    in_push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic cfg_put(input cfg_reg_t idx, input logic [48:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_FRAME_WIDTH:  cf_width  = data[10:0];
      REG_FRAME_HEIGHT: cf_height = data[10:0];
      REG_MASK_SIZE:    cf_size   = data[2:0];
      REG_MASK_BITS:    cf_bits   = data;
      REG_FILTER_MODE:  cf_mode   = data[0];
      default: ;
    endcase
  endtask

  function automatic void add_cfg(input cfg_reg_t idx, input logic [48:0] data);
    dir_rows.push_back('{ROW_CFG, idx, data, CMD_PIXEL, 8'd0, 0, 9'd0, 1'b0});
  endfunction

  function automatic void add_item(input logic cmd, input logic [7:0] pix);
    dir_rows.push_back('{ROW_ITEM, REG_FRAME_WIDTH, 49'd0, cmd, pix, 0, 9'd0, 1'b0});
  endfunction

  function automatic void add_fixed(input logic [7:0] pix, input logic [8:0] v);
    dir_rows.push_back('{ROW_ITEM, REG_FRAME_WIDTH, 49'd0, CMD_PIXEL, pix, 1, v, 1'b1});
  endfunction

  task automatic random_frame(input int phase);
    logic [10:0] w, hh;
    logic [48:0] bits;
    int n;
    settle();
    case (phase)
      2: begin w = 11'd40; hh = 11'd1; end
      4: begin w = 11'd1; hh = 11'd40; end
      default: begin
        w  = ($urandom_range(9) == 0) ? 11'd0 : 11'($urandom_range(12, 1));
        hh = ($urandom_range(9) == 0) ? 11'd0 : 11'($urandom_range(10, 1));
      end
    endcase
    case ($urandom_range(3))
      0: bits = '1;
      1: bits = '0;
      default: bits = 49'({$urandom, $urandom});
    endcase
    cfg_put(REG_FRAME_WIDTH, 49'(w));
    cfg_put(REG_FRAME_HEIGHT, 49'(hh));
    cfg_put(REG_MASK_SIZE, 49'($urandom_range(7)));
    cfg_put(REG_MASK_BITS, bits);
    cfg_put(REG_FILTER_MODE, 49'($urandom_range(1)));
    cfg_we <= 1'b0;
    settings_used++;
    n = ((w == 0) ? 1 : ((w > 1024) ? 1024 : w)) * ((hh == 0) ? 1 : ((hh > 1024) ? 1024 : hh));
    frame_closed = 0;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 8) send_item(CMD_DRAIN, 8'($urandom), 0, 9'd0, 1'b0);
      send_item(CMD_PIXEL, 8'($urandom), 0, 9'd0, 1'b0);
    end
    while (!frame_closed)
      send_item(($urandom_range(99) < 70) ? CMD_DRAIN : CMD_PIXEL, 8'($urandom), 0, 9'd0,
                1'b0);
    frames_closed++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result %0d", out_result_value));
      end else begin
        head = pending_results.pop_front();
        if (out_result_value !== head.val)
          report($sformatf("value %0d, want %0d", out_result_value, head.val));
        if (out_result_last !== head.last)
          report($sformatf("last %0b, want %0b", out_result_last, head.last));
      end
    end
    out_pop <= steady || ($urandom_range(99) >= 28);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    bit cfg_open;
    rst_n <= 1'b0;
    in_push <= 1'b0;
    in_cmd <= CMD_PIXEL;
    in_pixel_value <= '0;
    out_pop <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data <= '0;
    cf_width = RST_FRAME_WIDTH;
    cf_height = RST_FRAME_HEIGHT;
    cf_size = RST_MASK_SIZE;
    cf_bits = RST_MASK_BITS;
    cf_mode = RST_FILTER_MODE;
    px_row = 0; px_col = 0; res_row = 0; res_col = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-pixel frames from zero sizes, then empty-mask, full 7x7 and patterned 5x5 erosion windows
    add_cfg(REG_FRAME_WIDTH, 49'd0);
    add_cfg(REG_FRAME_HEIGHT, 49'd0);
    add_cfg(REG_MASK_SIZE, 49'd1);
    add_cfg(REG_MASK_BITS, 49'd1);
    add_cfg(REG_FILTER_MODE, 49'(MODE_DILATE));
    add_fixed(8'd255, 9'd255);
    add_fixed(8'd0, 9'd0);
    add_cfg(REG_FILTER_MODE, 49'(MODE_ERODE));
    add_cfg(REG_MASK_BITS, 49'd0);
    add_fixed(8'd7, ERODE_EMPTY);
    add_cfg(REG_FILTER_MODE, 49'(MODE_DILATE));
    add_fixed(8'd200, DILATE_EMPTY);
    add_cfg(REG_FRAME_WIDTH, 49'd3);
    add_cfg(REG_FRAME_HEIGHT, 49'd2);
    add_cfg(REG_MASK_SIZE, 49'd6);
    add_cfg(REG_MASK_BITS, '1);
    add_item(CMD_PIXEL, 8'd10);
    add_item(CMD_PIXEL, 8'd255);
    add_item(CMD_DRAIN, 8'd77);
    add_item(CMD_PIXEL, 8'd0);
    add_item(CMD_PIXEL, 8'd37);
    add_item(CMD_PIXEL, 8'd128);
    add_item(CMD_PIXEL, 8'd1);
    repeat (3) add_item(CMD_DRAIN, 8'd0);
    repeat (3) add_item(CMD_PIXEL, 8'd99);
    add_cfg(REG_MASK_SIZE, 49'd4);
    add_cfg(REG_FILTER_MODE, 49'(MODE_ERODE));
    add_cfg(REG_MASK_BITS, 49'h0_0A5A_5F3C);
    for (int i = 0; i < 6; i++) add_item(CMD_PIXEL, 8'(40 * i + 3));
    repeat (6) add_item(CMD_DRAIN, 8'hFF);

    cfg_open = 0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        if (!cfg_open) settle();
        cfg_open = 1;
        cfg_put(dir_rows[i].reg_idx, dir_rows[i].data);
      end else begin
        if (cfg_open) cfg_we <= 1'b0;
        cfg_open = 0;
        send_item(dir_rows[i].cmd, dir_rows[i].pix, dir_rows[i].fixed,
                  dir_rows[i].fix_val, dir_rows[i].fix_last);
      end
    end
    settings_used = 4;

    for (int phase = 0; items_sent < dir_rows.size() + RANDOM_ITEMS || phase < 6; phase++)
      random_frame(phase);

    in_push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d items, %0d results, %0d random frames, %0d register settings",
             items_sent, results_seen, frames_closed, settings_used);
    $display("dilation and erosion, mask sizes 1..7, single-row and single-column strips");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/gmf_pkg.sv
design/gmf_front.sv
design/gmf_colq.sv
design/gmf_back.sv
design/grayscale_morphology_filter.sv
bench/tb_top.sv
